// File: rtl/tzs_pkg.sv
// shared types and constants for the triangle rasterizer with depth buffer
// used by every module under rtl
`default_nettype none
package tzs_pkg;

  localparam int DEF_WIDTH  = 256;
  localparam int DEF_HEIGHT = 256;

  localparam int DEPTH_W = 24;
  localparam int CHAN_W  = 8;
  localparam int COLOR_W = 3 * CHAN_W;
  localparam logic [DEPTH_W-1:0] MAX_DEPTH = 24'h7FFFFF;
  localparam logic [CHAN_W-1:0]  CHAN_MAX  = 8'd255;

  localparam int EW = 38;
  localparam int BW = 25;
  localparam int PW = 64;
  localparam int QW = 24;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_SHADE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  typedef struct packed {
    logic [1:0]                opcode;
    logic [1:0]                vertex_slot;
    logic signed [15:0]        vert_x;
    logic signed [15:0]        vert_y;
    logic signed [DEPTH_W-1:0] vert_z;
    logic [CHAN_W-1:0]         vert_red;
    logic [CHAN_W-1:0]         vert_green;
    logic [CHAN_W-1:0]         vert_blue;
    logic [7:0]                pixel_x;
    logic [7:0]                pixel_y;
  } in_item_t;

  typedef struct packed {
    logic                      covered;
    logic                      depth_passed;
    logic [CHAN_W-1:0]         out_red;
    logic [CHAN_W-1:0]         out_green;
    logic [CHAN_W-1:0]         out_blue;
    logic signed [DEPTH_W-1:0] out_depth;
  } out_item_t;

endpackage
`default_nettype wire

// File: rtl/tzs_mul.sv
// shift-add signed multiplier, one multiplier bit per cycle
// depends on tzs_pkg
`default_nettype none
module tzs_mul (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic signed [tzs_pkg::EW-1:0] a,
  input  wire logic signed [tzs_pkg::BW-1:0] b,
  output logic                               done,
  output logic signed [tzs_pkg::PW-1:0]      prod
);
  import tzs_pkg::*;

  localparam int CW = $clog2(BW);

  logic [PW-1:0] a_sh_r;
  logic [BW-1:0] b_sh_r;
  logic [PW-1:0] acc_r;
  logic [CW-1:0] cnt_r;
  logic          neg_r;
  logic          busy_r;
  logic          done_r;
  logic [EW-1:0] mag_a;
  logic [BW-1:0] mag_b;

  assign mag_a = a[EW-1] ? EW'(-a) : EW'(a);
  assign mag_b = b[BW-1] ? BW'(-b) : BW'(b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CW'(BW - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_sh_r <= PW'(mag_a);
      b_sh_r <= mag_b;
      acc_r  <= '0;
      cnt_r  <= '0;
      neg_r  <= a[EW-1] ^ b[BW-1];
    end else if (busy_r) begin
      if (b_sh_r[0]) begin
        acc_r <= acc_r + a_sh_r;
      end
      a_sh_r <= a_sh_r << 1;
      b_sh_r <= b_sh_r >> 1;
      cnt_r  <= cnt_r + CW'(1);
    end
  end

  assign done = done_r;
  assign prod = neg_r ? -signed'(acc_r) : signed'(acc_r);

endmodule
`default_nettype wire

// File: rtl/tzs_div.sv
// restoring divider, signed dividend over positive divisor, truncating
// one quotient bit per cycle; depends on tzs_pkg
`default_nettype none
module tzs_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic signed [tzs_pkg::PW-1:0] num,
  input  wire logic [tzs_pkg::EW-1:0]        den,
  output logic                               done,
  output logic signed [tzs_pkg::QW:0]        quot
);
  import tzs_pkg::*;

  localparam int CW = $clog2(QW);

  logic [PW-1:0] mag_n;
  logic [EW:0]   rem_r;
  logic [QW-1:0] low_r;
  logic [QW-1:0] q_r;
  logic [EW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          neg_r;
  logic          busy_r;
  logic          done_r;
  logic [EW:0]   trial;
  logic          fits;

  assign mag_n = num[PW-1] ? PW'(-num) : PW'(num);
  assign trial = {rem_r[EW-1:0], low_r[QW-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CW'(QW - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= (EW + 1)'(mag_n >> QW);
      low_r <= mag_n[QW-1:0];
      den_r <= den;
      q_r   <= '0;
      cnt_r <= '0;
      neg_r <= num[PW-1];
    end else if (busy_r) begin
      rem_r <= fits ? trial - {1'b0, den_r} : trial;
      low_r <= low_r << 1;
      q_r   <= {q_r[QW-2:0], fits};
      cnt_r <= cnt_r + CW'(1);
    end
  end

  assign done = done_r;
  assign quot = neg_r ? -signed'({1'b0, q_r}) : signed'({1'b0, q_r});

endmodule
`default_nettype wire

// File: rtl/triangle_zbuffer_shader.sv
// triangle rasterizer with depth and color buffers, one item at a time
// a clear walks every pixel; a shade runs its products one after another through the serial
// multiplier and its divisions through the serial divider, which set its time; the block
// returns to S_IDLE after each result, and a stalled result holds the next one in S_FIN
// synchronous reset; after reset a pass over every pixel sets the depth buffer to maximum
// and colors to zero before any item is taken
`default_nettype none
module triangle_zbuffer_shader #(
  parameter int IMAGE_WIDTH  = tzs_pkg::DEF_WIDTH,
  parameter int IMAGE_HEIGHT = tzs_pkg::DEF_HEIGHT
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic               cfg_wr_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire tzs_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output tzs_pkg::out_item_t      out_data
);
  import tzs_pkg::*;

  localparam int PIXELS = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int AW     = $clog2(PIXELS);
  localparam int YW     = $clog2(IMAGE_HEIGHT);
  localparam int MW     = DEPTH_W + COLOR_W;

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_RD     = 4'd2;
  localparam logic [3:0] S_GOT    = 4'd3;
  localparam logic [3:0] S_MSTART = 4'd4;
  localparam logic [3:0] S_MWAIT  = 4'd5;
  localparam logic [3:0] S_DET    = 4'd6;
  localparam logic [3:0] S_CHK    = 4'd7;
  localparam logic [3:0] S_DSTART = 4'd8;
  localparam logic [3:0] S_DWAIT  = 4'd9;
  localparam logic [3:0] S_WR     = 4'd10;
  localparam logic [3:0] S_FIN    = 4'd11;

  logic [3:0]                state_r, state_nxt;
  logic                      mode_r;
  logic signed [15:0]        cx_r [3];
  logic signed [15:0]        cy_r [3];
  logic signed [DEPTH_W-1:0] cz_r [3];
  logic [COLOR_W-1:0]        cc_r [3];
  logic [AW-1:0]             clr_cnt_r;
  logic                      clr_op_r;
  logic [AW-1:0]             addr_r;
  logic [1:0]                op_r;
  logic [15:0]               px_r, py_r;
  logic [2:0]                step_r;
  logic                      edge_ph_r;
  logic [1:0]                ch_r;
  logic signed [EW-1:0]      e_r [3];
  logic signed [EW-1:0]      det_r;
  logic signed [PW-1:0]      acc_r;
  logic signed [DEPTH_W-1:0] new_z_r;
  logic [COLOR_W-1:0]        new_c_r;
  out_item_t                 res_r;
  out_item_t                 out_r;
  logic                      out_valid_r;

  logic [MW-1:0]             mem [PIXELS];
  logic [MW-1:0]             rd_q;
  logic                      mem_we;
  logic [AW-1:0]             mem_wa;
  logic [MW-1:0]             mem_wd;

  logic signed [EW-1:0]      mul_a;
  logic signed [BW-1:0]      mul_b;
  logic                      mul_start, mul_done;
  logic signed [PW-1:0]      mul_p;
  logic                      div_start, div_done;
  logic signed [QW:0]        div_q;

  logic                      in_range;
  logic [YW-1:0]             row_c;
  logic [AW-1:0]             addr_c;
  logic signed [EW-1:0]      det_c;
  logic signed [17:0]        psx, psy;
  logic [1:0]                ia, ib;
  logic signed [17:0]        dxa, dya;
  logic signed [EW-1:0]      e_sel;
  logic [1:0]                term;
  logic [CHAN_W-1:0]         chan_q;
  logic                      out_free;
  logic signed [DEPTH_W-1:0] st_z;
  logic [COLOR_W-1:0]        st_c;

  tzs_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  tzs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (acc_r),
    .den   (EW'(det_r)),
    .done  (div_done),
    .quot  (div_q)
  );

  assign in_range = (int'(in_data.pixel_x) < IMAGE_WIDTH) &&
                    (int'(in_data.pixel_y) < IMAGE_HEIGHT);
  assign row_c    = YW'(IMAGE_HEIGHT - 1 - int'(in_data.pixel_y));
  assign addr_c   = AW'(in_data.pixel_x) + AW'(row_c) * AW'(IMAGE_WIDTH);
  assign det_c    = e_r[0] + e_r[1] + e_r[2];
  assign st_z     = rd_q[DEPTH_W-1:0];
  assign st_c     = rd_q[MW-1:DEPTH_W];
  assign out_free = !out_valid_r || !out_stall;
  assign psx      = signed'({2'b00, px_r});
  assign psy      = signed'({2'b00, py_r});
  assign term     = step_r[1:0];

  // operand selection for the shared multiplier
  always_comb begin
    ia = 2'd1;
    ib = 2'd2;
    unique case (step_r[2:1])
      2'd0: begin ia = 2'd1; ib = 2'd2; end
      2'd1: begin ia = 2'd2; ib = 2'd0; end
      2'd2: begin ia = 2'd0; ib = 2'd1; end
      default: begin ia = 2'd1; ib = 2'd2; end
    endcase
    dxa = 18'sd0;
    dya = 18'sd0;
    unique case (ia)
      2'd0: begin dxa = 18'(cx_r[0]); dya = 18'(cy_r[0]); end
      2'd1: begin dxa = 18'(cx_r[1]); dya = 18'(cy_r[1]); end
      2'd2: begin dxa = 18'(cx_r[2]); dya = 18'(cy_r[2]); end
      default: begin dxa = 18'sd0; dya = 18'sd0; end
    endcase
    e_sel = e_r[0];
    unique case (term)
      2'd0: e_sel = e_r[0];
      2'd1: e_sel = e_r[1];
      2'd2: e_sel = e_r[2];
      default: e_sel = e_r[0];
    endcase
    mul_a = '0;
    mul_b = '0;
    if (edge_ph_r) begin
      unique case (ib)
        2'd0: begin
          mul_a = step_r[0] ? EW'(18'(cy_r[0]) - dya) : EW'(18'(cx_r[0]) - dxa);
        end
        2'd1: begin
          mul_a = step_r[0] ? EW'(18'(cy_r[1]) - dya) : EW'(18'(cx_r[1]) - dxa);
        end
        default: begin
          mul_a = step_r[0] ? EW'(18'(cy_r[2]) - dya) : EW'(18'(cx_r[2]) - dxa);
        end
      endcase
      mul_b = step_r[0] ? BW'(psx - dxa) : BW'(psy - dya);
    end else begin
      mul_a = e_sel;
      unique case (ch_r)
        2'd0: begin
          unique case (term)
            2'd0: mul_b = BW'(cz_r[0]);
            2'd1: mul_b = BW'(cz_r[1]);
            default: mul_b = BW'(cz_r[2]);
          endcase
        end
        default: begin
          unique case (term)
            2'd0: mul_b = BW'(signed'({1'b0, cc_r[0][(ch_r-2'd1)*CHAN_W +: CHAN_W]}));
            2'd1: mul_b = BW'(signed'({1'b0, cc_r[1][(ch_r-2'd1)*CHAN_W +: CHAN_W]}));
            default: mul_b = BW'(signed'({1'b0, cc_r[2][(ch_r-2'd1)*CHAN_W +: CHAN_W]}));
          endcase
        end
      endcase
    end
  end

  always_comb begin
    if (div_q < 0) begin
      chan_q = '0;
    end else if (div_q > (QW + 1)'(CHAN_MAX)) begin
      chan_q = CHAN_MAX;
    end else begin
      chan_q = div_q[CHAN_W-1:0];
    end
  end

  assign mul_start = (state_r == S_MSTART);
  assign div_start = (state_r == S_DSTART);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = addr_r;
    mem_wd = {new_c_r, new_z_r};
    if (state_r == S_CLR) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_r;
      mem_wd = {{COLOR_W{1'b0}}, MAX_DEPTH};
    end else if (state_r == S_WR) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[addr_r];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:    if (clr_cnt_r == AW'(PIXELS - 1)) state_nxt = clr_op_r ? S_FIN : S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_data.opcode)
            OP_CLEAR: state_nxt = S_CLR;
            OP_LOAD:  state_nxt = S_FIN;
            default:  state_nxt = in_range ? S_RD : S_FIN;
          endcase
        end
      end
      S_RD:     state_nxt = S_GOT;
      S_GOT:    state_nxt = (op_r == OP_SHADE) ? S_MSTART : S_FIN;
      S_MSTART: state_nxt = S_MWAIT;
      S_MWAIT: begin
        if (mul_done) begin
          if (edge_ph_r) begin
            state_nxt = (step_r == 3'd5) ? S_DET : S_MSTART;
          end else begin
            state_nxt = (term == 2'd2) ? S_DSTART : S_MSTART;
          end
        end
      end
      S_DET:    state_nxt = (det_c == 0) ? S_FIN : S_CHK;
      S_CHK: begin
        if (e_r[0] < 0 || e_r[1] < 0 || e_r[2] < 0 ||
            e_r[0] > det_r || e_r[1] > det_r || e_r[2] > det_r) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_MSTART;
        end
      end
      S_DSTART: state_nxt = S_DWAIT;
      S_DWAIT: begin
        if (div_done) begin
          if (ch_r == 2'd0) begin
            if (div_q >= (QW + 1)'(st_z)) state_nxt = S_FIN;
            else state_nxt = mode_r ? S_MSTART : S_WR;
          end else begin
            state_nxt = (ch_r == 2'd3) ? S_WR : S_MSTART;
          end
        end
      end
      S_WR:     state_nxt = S_FIN;
      S_FIN:    if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      clr_op_r    <= 1'b0;
      mode_r      <= 1'b1;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        cx_r[i] <= '0;
        cy_r[i] <= '0;
        cz_r[i] <= '0;
        cc_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      if (state_r == S_CLR) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_IDLE && in_valid) begin
        clr_cnt_r <= '0;
        clr_op_r  <= 1'b1;
        if (in_data.opcode == OP_LOAD) begin
          unique case (in_data.vertex_slot)
            2'd0: begin
              cx_r[0] <= in_data.vert_x;
              cy_r[0] <= in_data.vert_y;
              cz_r[0] <= in_data.vert_z;
              cc_r[0] <= {in_data.vert_blue, in_data.vert_green, in_data.vert_red};
            end
            2'd1: begin
              cx_r[1] <= in_data.vert_x;
              cy_r[1] <= in_data.vert_y;
              cz_r[1] <= in_data.vert_z;
              cc_r[1] <= {in_data.vert_blue, in_data.vert_green, in_data.vert_red};
            end
            2'd2: begin
              cx_r[2] <= in_data.vert_x;
              cy_r[2] <= in_data.vert_y;
              cz_r[2] <= in_data.vert_z;
              cc_r[2] <= {in_data.vert_blue, in_data.vert_green, in_data.vert_red};
            end
            default: ;
          endcase
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == S_FIN && out_free) begin
      out_r <= res_r;
    end
    unique case (state_r)
      S_IDLE: begin
        res_r     <= '0;
        op_r      <= in_data.opcode;
        addr_r    <= addr_c;
        px_r      <= {4'd0, in_data.pixel_x, 4'd0};
        py_r      <= {4'd0, in_data.pixel_y, 4'd0};
        step_r    <= '0;
        edge_ph_r <= 1'b1;
        ch_r      <= '0;
      end
      S_GOT: begin
        res_r.out_red   <= st_c[CHAN_W-1:0];
        res_r.out_green <= st_c[2*CHAN_W-1:CHAN_W];
        res_r.out_blue  <= st_c[COLOR_W-1:2*CHAN_W];
        res_r.out_depth <= st_z;
      end
      S_MWAIT: begin
        if (mul_done) begin
          if (edge_ph_r) begin
            if (!step_r[0]) begin
              acc_r <= mul_p;
            end else begin
              unique case (step_r[2:1])
                2'd0: e_r[0] <= EW'(acc_r - mul_p);
                2'd1: e_r[1] <= EW'(acc_r - mul_p);
                default: e_r[2] <= EW'(acc_r - mul_p);
              endcase
            end
            step_r <= step_r + 3'd1;
          end else begin
            acc_r  <= (term == 2'd0) ? mul_p : acc_r + mul_p;
            step_r <= (term == 2'd2) ? 3'd0 : step_r + 3'd1;
          end
        end
      end
      S_DET: begin
        if (det_c < 0) begin
          det_r  <= -det_c;
          e_r[0] <= -e_r[0];
          e_r[1] <= -e_r[1];
          e_r[2] <= -e_r[2];
        end else begin
          det_r <= det_c;
        end
      end
      S_CHK: begin
        res_r.covered <= !(e_r[0] < 0 || e_r[1] < 0 || e_r[2] < 0 ||
                           e_r[0] > det_r || e_r[1] > det_r || e_r[2] > det_r);
        edge_ph_r     <= 1'b0;
        step_r        <= '0;
      end
      S_DWAIT: begin
        if (div_done) begin
          ch_r <= ch_r + 2'd1;
          if (ch_r == 2'd0) begin
            new_z_r <= div_q[DEPTH_W-1:0];
            new_c_r <= cc_r[0];
          end else begin
            new_c_r[(ch_r-2'd1)*CHAN_W +: CHAN_W] <= chan_q;
          end
        end
      end
      S_WR: begin
        res_r.depth_passed <= 1'b1;
        res_r.out_red      <= new_c_r[CHAN_W-1:0];
        res_r.out_green    <= new_c_r[2*CHAN_W-1:CHAN_W];
        res_r.out_blue     <= new_c_r[COLOR_W-1:2*CHAN_W];
        res_r.out_depth    <= new_z_r;
      end
      default: ;
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// File: test/triangle_zbuffer_shader_test.sv
// testbench for triangle_zbuffer_shader: directed and random items against a
// predictor of the depth and color buffers, with random idling on both sides
// depends on rtl/tzs_pkg.sv and rtl/triangle_zbuffer_shader.sv
module triangle_zbuffer_shader_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tzs_pkg::*;

  class raster_scoreboard;
    bit                        color_mode = 1'b1;
    logic signed [15:0]        cx[3], cy[3];
    logic signed [DEPTH_W-1:0] cz[3];
    logic [COLOR_W-1:0]        ccol[3];
    logic signed [DEPTH_W-1:0] zbuf[65536];
    logic [COLOR_W-1:0]        cbuf[65536];
    out_item_t                 pending[$];
    int                        errors = 0;

    function new();
      for (int i = 0; i < 3; i++) begin
        cx[i] = '0; cy[i] = '0; cz[i] = '0; ccol[i] = '0;
      end
      wipe();
    endfunction

    function void wipe();
      for (int i = 0; i < 65536; i++) begin
        zbuf[i] = MAX_DEPTH;
        cbuf[i] = '0;
      end
    endfunction

    function longint edge_fn(longint ax, longint ay, longint bx, longint by,
                             longint px, longint py);
      return (bx - ax) * (py - ay) - (by - ay) * (px - ax);
    endfunction

    function void shade(logic [15:0] idx, longint px, longint py, ref out_item_t r);
      longint e[3], det, num, c;
      logic [COLOR_W-1:0] col;
      e[0] = edge_fn(longint'(cx[1]), longint'(cy[1]), longint'(cx[2]), longint'(cy[2]),
                     px, py);
      e[1] = edge_fn(longint'(cx[2]), longint'(cy[2]), longint'(cx[0]), longint'(cy[0]),
                     px, py);
      e[2] = edge_fn(longint'(cx[0]), longint'(cy[0]), longint'(cx[1]), longint'(cy[1]),
                     px, py);
      det = e[0] + e[1] + e[2];
      if (det == 0) return;
      if (det < 0) begin
        det = -det;
        for (int i = 0; i < 3; i++) e[i] = -e[i];
      end
      for (int i = 0; i < 3; i++)
        if (e[i] < 0 || e[i] > det) return;
      r.covered = 1'b1;
      num = 0;
      for (int i = 0; i < 3; i++) num += e[i] * longint'(cz[i]);
      num = num / det;
      if (num >= longint'(zbuf[idx])) return;
      r.depth_passed = 1'b1;
      zbuf[idx] = num[DEPTH_W-1:0];
      if (!color_mode) begin
        col = ccol[0];
      end else begin
        for (int k = 0; k < 3; k++) begin
          c = 0;
          for (int i = 0; i < 3; i++) c += e[i] * longint'(ccol[i][8*k +: 8]);
          c = c / det;
          if (c < 0) c = 0;
          if (c > 255) c = 255;
          col[8*k +: 8] = c[7:0];
        end
      end
      cbuf[idx] = col;
    endfunction

    function void note(in_item_t it);
      out_item_t r;
      logic [15:0] idx;
      r = '0;
      case (it.opcode)
        OP_CLEAR: wipe();
        OP_LOAD: begin
          if (it.vertex_slot < 3) begin
            cx[it.vertex_slot] = it.vert_x;
            cy[it.vertex_slot] = it.vert_y;
            cz[it.vertex_slot] = it.vert_z;
            ccol[it.vertex_slot] = {it.vert_blue, it.vert_green, it.vert_red};
          end
        end
        default: begin
          idx = {~it.pixel_y, it.pixel_x};
          if (it.opcode == OP_SHADE)
            shade(idx, longint'(it.pixel_x) * 16, longint'(it.pixel_y) * 16, r);
          r.out_red   = cbuf[idx][7:0];
          r.out_green = cbuf[idx][15:8];
          r.out_blue  = cbuf[idx][23:16];
          r.out_depth = zbuf[idx];
        end
      endcase
      pending = {pending, r};
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check(out_item_t got);
      out_item_t w;
      if (pending.size() == 0) begin
        report("result transfer with nothing pending");
        return;
      end
      w = pending.pop_front();
      if (got.covered !== w.covered)
        report($sformatf("covered %0b want %0b", got.covered, w.covered));
      if (got.depth_passed !== w.depth_passed)
        report($sformatf("depth_passed %0b want %0b", got.depth_passed, w.depth_passed));
      if (got.out_red !== w.out_red)
        report($sformatf("red %0d want %0d", got.out_red, w.out_red));
      if (got.out_green !== w.out_green)
        report($sformatf("green %0d want %0d", got.out_green, w.out_green));
      if (got.out_blue !== w.out_blue)
        report($sformatf("blue %0d want %0d", got.out_blue, w.out_blue));
      if (got.out_depth !== w.out_depth)
        report($sformatf("depth %0d want %0d", got.out_depth, w.out_depth));
    endtask
  endclass

  logic      clk;
  logic      rst_n;
  logic      cfg_wr_en;
  logic      cfg_wr_data;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  raster_scoreboard sb = new();
  bit idle_on = 1'b1;

  triangle_zbuffer_shader dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #60ms;
    $display("Some tests failed");
    $finish;
  end

  task send(in_item_t it);
    int gap;
    gap = idle_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sb.note(it);
  endtask

  function in_item_t noise_item();
    in_item_t it;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    return it;
  endfunction

  task load(logic [1:0] slot, logic signed [15:0] x, logic signed [15:0] y,
            logic signed [23:0] z, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    in_item_t it;
    it = noise_item();
    it.opcode = OP_LOAD;
    it.vertex_slot = slot;
    it.vert_x = x; it.vert_y = y; it.vert_z = z;
    it.vert_red = r; it.vert_green = g; it.vert_blue = b;
    send(it);
  endtask

  task pixel_op(logic [1:0] op, logic [7:0] x, logic [7:0] y);
    in_item_t it;
    it = noise_item();
    it.opcode = op;
    it.pixel_x = x;
    it.pixel_y = y;
    send(it);
  endtask

  task drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task set_mode(bit m);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.color_mode = m;
  endtask

  task random_phase(int n);
    int cnt, r, k, x0, x1, y0, y1;
    logic signed [15:0] vx[3], vy[3];
    cnt = 0;
    while (cnt < n) begin
      r = $urandom_range(0, 999);
      if (r < 3) begin
        pixel_op(OP_CLEAR, 0, 0);
        cnt++;
      end else if (r < 50) begin
        send(noise_item());
        cnt++;
      end else begin
        for (int i = 0; i < 3; i++) begin
          vx[i] = 16'($urandom_range(0, 4095));
          vy[i] = 16'($urandom_range(0, 4095));
          load(2'(i), vx[i], vy[i], 24'($urandom), 8'($urandom), 8'($urandom),
               8'($urandom));
        end
        x0 = int'(vx[0]); x1 = int'(vx[0]); y0 = int'(vy[0]); y1 = int'(vy[0]);
        for (int i = 1; i < 3; i++) begin
          if (vx[i] < x0) x0 = int'(vx[i]);
          if (vx[i] > x1) x1 = int'(vx[i]);
          if (vy[i] < y0) y0 = int'(vy[i]);
          if (vy[i] > y1) y1 = int'(vy[i]);
        end
        x0 = x0 >> 4; x1 = x1 >> 4; y0 = y0 >> 4; y1 = y1 >> 4;
        k = $urandom_range(4, 12);
        for (int j = 0; j < k; j++)
          pixel_op($urandom_range(0, 6) == 0 ? OP_READ : OP_SHADE,
                   8'($urandom_range(x0, x1)), 8'($urandom_range(y0, y1)));
        cnt += 3 + k;
      end
    end
  endtask

  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      int n;
      n = idle_on ? $urandom_range(0, 12) : 0;
      out_stall <= (n > 0);
      if (n > 0) begin
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
      sb.check(out_data);
    end
  end

  initial begin
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // right triangle at origin, interpolated colors
    load(0, 0, 0, -24'sd8388608, 255, 0, 0);
    load(1, 1600, 0, 24'sd1000, 0, 255, 0);
    load(2, 0, 1600, 24'sd8388607, 0, 0, 255);
    pixel_op(OP_SHADE, 0, 0);
    pixel_op(OP_SHADE, 0, 0);
    pixel_op(OP_SHADE, 20, 30);
    pixel_op(OP_SHADE, 100, 0);
    pixel_op(OP_SHADE, 0, 100);
    pixel_op(OP_SHADE, 60, 60);
    pixel_op(OP_SHADE, 255, 255);
    pixel_op(OP_READ, 20, 30);
    pixel_op(OP_READ, 0, 255);
    load(3, -32768, 32767, 24'sd5, 1, 2, 3);
    pixel_op(OP_SHADE, 10, 10);
    // clockwise winding
    load(1, 0, 1600, 24'sd0, 0, 0, 0);
    load(2, 1600, 0, -24'sd100, 255, 255, 255);
    pixel_op(OP_SHADE, 40, 40);
    // degenerate: all corners on one line
    load(2, 0, 3200, -24'sd5, 9, 9, 9);
    pixel_op(OP_SHADE, 0, 50);
    load(0, -32768, -32768, 24'sd0, 0, 0, 0);
    load(1, 32767, 32767, 24'sd0, 0, 0, 0);
    pixel_op(OP_CLEAR, 0, 0);
    pixel_op(OP_READ, 20, 30);
    drain();

    set_mode(1'b0);
    load(0, 0, 0, -24'sd10, 12, 34, 56);
    load(1, 4080, 0, -24'sd10, 200, 0, 0);
    load(2, 0, 4080, -24'sd10, 0, 200, 0);
    pixel_op(OP_SHADE, 5, 5);
    pixel_op(OP_SHADE, 255, 0);
    drain();

    random_phase(450);
    drain();
    set_mode(1'b1);
    idle_on = 1'b0;
    random_phase(450);
    drain();
    idle_on = 1'b1;
    set_mode(1'b0);
    random_phase(450);
    drain();
    set_mode(1'b1);
    random_phase(450);
    drain();

    if (sb.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule

// File: filelist.f
rtl/tzs_pkg.sv
rtl/tzs_mul.sv
rtl/tzs_div.sv
rtl/triangle_zbuffer_shader.sv
test/triangle_zbuffer_shader_test.sv
